### src/rplm_pkg.sv
package rplm_pkg;

   // fixed sizes of the frame and result fields
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 41;
   localparam int COUNT_W  = 11;
   localparam int DIVISOR_W = COUNT_W + 1;
   localparam int LEVEL_W  = 12;
   localparam int GAIN_W   = 16;
   localparam int PROD_W   = 2 * SAMPLE_W;

   // channel count and block length limits of the meter
   localparam int MAX_CHANNELS     = 2;
   localparam int MAX_BLOCK_FRAMES = 1024;

   // restoring divide of the sum and digit-by-digit square root
   localparam int DIV_STEPS  = SUM_W;
   localparam int ROOT_STEPS = (SUM_W + 1) / 2;
   localparam int ITER_W     = $clog2(DIV_STEPS);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NUM_CHANNELS        = 3'd0,
      CSR_FRAMES_PER_BLOCK    = 3'd1,
      CSR_RMS_GAIN            = 3'd2,
      CSR_PEAK_GAIN           = 3'd3,
      CSR_FULL_SCALE          = 3'd4,
      CSR_LOW_LEVEL_THRESHOLD = 3'd5,
      CSR_PEAK_MINIMUM        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [1:0]          num_channels;
      logic [COUNT_W-1:0]  frames_per_block;
      logic [GAIN_W-1:0]   rms_gain;
      logic [GAIN_W-1:0]   peak_gain;
      logic [LEVEL_W-1:0]  full_scale;
      logic [LEVEL_W-1:0]  low_level_threshold;
      logic [SAMPLE_W-1:0] peak_minimum;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      num_channels:        2'd1,
      frames_per_block:    11'd256,
      rms_gain:            16'd12800,
      peak_gain:           16'd2560,
      full_scale:          12'd2560,
      low_level_threshold: 12'd26,
      peak_minimum:        16'd328
   };

   typedef struct packed {
      logic load;        // frame transfer, capture magnitude
      logic accumulate;  // add square, update peak
      logic div_init;
      logic div_step;
      logic root_init;
      logic root_step;
      logic mul_load;
      logic mul_peak;    // select peak and peak gain
      logic level_load;
      logic emit;        // result register load, accumulators clear
   } cmd_type;

   typedef struct packed {
      logic block_end;
      logic fallback;
   } status_type;

endpackage

### src/rplm_csr.sv
module rplm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rplm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rplm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rplm_pkg::cfg_type               cfg
);
   import rplm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_NUM_CHANNELS:        cfg_in.num_channels        = csr_wdata[1:0];
            CSR_FRAMES_PER_BLOCK:    cfg_in.frames_per_block    = csr_wdata[COUNT_W-1:0];
            CSR_RMS_GAIN:            cfg_in.rms_gain            = csr_wdata[GAIN_W-1:0];
            CSR_PEAK_GAIN:           cfg_in.peak_gain           = csr_wdata[GAIN_W-1:0];
            CSR_FULL_SCALE:          cfg_in.full_scale          = csr_wdata[LEVEL_W-1:0];
            CSR_LOW_LEVEL_THRESHOLD: cfg_in.low_level_threshold = csr_wdata[LEVEL_W-1:0];
            CSR_PEAK_MINIMUM:        cfg_in.peak_minimum        = csr_wdata[SAMPLE_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/rplm_datapath.sv
module rplm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rplm_pkg::cfg_type                    cfg,
   input  rplm_pkg::cmd_type                    cmd,
   output rplm_pkg::status_type                 status,
   input  logic signed [rplm_pkg::SAMPLE_W-1:0] sample_ch0,
   input  logic signed [rplm_pkg::SAMPLE_W-1:0] sample_ch1,
   output logic [rplm_pkg::LEVEL_W-1:0]         level,
   output logic [rplm_pkg::SAMPLE_W-1:0]        rms_value,
   output logic [rplm_pkg::SAMPLE_W-1:0]        peak_value,
   output logic                                 used_peak
);
   import rplm_pkg::*;

   localparam logic [SUM_W-1:0] ROOT_BIT_START = {1'b1, {(SUM_W-1){1'b0}}};

   // mono mix and magnitude
   logic signed [SAMPLE_W:0]   mix_sum;
   logic signed [SAMPLE_W-1:0] mono;
   logic [SAMPLE_W-1:0]        mag;
   logic                       avg_mode;
   logic [COUNT_W-1:0]         len_eff;
   logic [DIVISOR_W-1:0]       divisor;

   logic [SAMPLE_W-1:0]  mag_ff, mag_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SAMPLE_W-1:0]  peak_ff, peak_in;
   logic [PROD_W-1:0]    square;

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]     work_ff, work_in;
   logic [SUM_W-1:0]     res_ff, res_in;
   logic [SUM_W-1:0]     bit_ff, bit_in;
   logic [DIVISOR_W:0]   div_trial;
   logic                 div_ge;
   logic [SUM_W-1:0]     root_trial;
   logic                 root_ge;

   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [SAMPLE_W-1:0]  mul_a;
   logic [GAIN_W-1:0]    mul_b;
   logic [PROD_W-SAMPLE_W:0] scaled;
   logic [LEVEL_W-1:0]   clamped;

   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 used_ff, used_in;
   logic [LEVEL_W-1:0]   out_level_ff, out_level_in;
   logic [SAMPLE_W-1:0]  out_rms_ff, out_rms_in;
   logic [SAMPLE_W-1:0]  out_peak_ff, out_peak_in;
   logic                 out_used_ff, out_used_in;

   always_comb begin
      avg_mode = (cfg.num_channels >= 2'd2) && (MAX_CHANNELS >= 2);
      mix_sum  = $signed({sample_ch0[SAMPLE_W-1], sample_ch0})
               + $signed({sample_ch1[SAMPLE_W-1], sample_ch1});
      // arithmetic halving rounds toward minus infinity
      mono = avg_mode ? mix_sum[SAMPLE_W:1] : sample_ch0;
      mag  = mono[SAMPLE_W-1] ? (~mono + SAMPLE_W'(1)) : mono;

      if (cfg.frames_per_block == '0) begin
         len_eff = COUNT_W'(1);
      end else if (17'(cfg.frames_per_block) > 17'(MAX_BLOCK_FRAMES)) begin
         len_eff = COUNT_W'(MAX_BLOCK_FRAMES);
      end else begin
         len_eff = cfg.frames_per_block;
      end
      // a wrapped counter stands for a full count of frames
      divisor = {count_ff == '0, count_ff};
   end

   assign square = mag_ff * mag_ff;

   // accumulation
   always_comb begin
      mag_in   = mag_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      peak_in  = peak_ff;
      if (cmd.load) begin
         mag_in   = mag;
         count_in = count_ff + COUNT_W'(1);
      end
      if (cmd.accumulate) begin
         sum_in = sum_ff + SUM_W'(square);
         if (mag_ff > peak_ff) begin
            peak_in = mag_ff;
         end
      end
      if (cmd.emit) begin
         count_in = '0;
         sum_in   = '0;
         peak_in  = '0;
      end
   end

   // divide and square root share the work register
   always_comb begin
      div_trial  = {rem_ff, work_ff[SUM_W-1]} - {1'b0, divisor};
      div_ge     = !div_trial[DIVISOR_W];
      root_trial = res_ff + bit_ff;
      root_ge    = work_ff >= root_trial;

      rem_in  = rem_ff;
      work_in = work_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      priority if (cmd.div_init) begin
         rem_in  = '0;
         work_in = sum_ff;
      end else if (cmd.div_step) begin
         rem_in  = div_ge ? div_trial[DIVISOR_W-1:0]
                          : {rem_ff[DIVISOR_W-2:0], work_ff[SUM_W-1]};
         work_in = {work_ff[SUM_W-2:0], div_ge};
      end else if (cmd.root_init) begin
         res_in = '0;
         bit_in = ROOT_BIT_START;
      end else if (cmd.root_step) begin
         if (root_ge) begin
            work_in = work_ff - root_trial;
            res_in  = (res_ff >> 1) + bit_ff;
         end else begin
            res_in  = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   // scaling to volts
   always_comb begin
      mul_a   = cmd.mul_peak ? peak_ff : res_ff[SAMPLE_W-1:0];
      mul_b   = cmd.mul_peak ? cfg.peak_gain : cfg.rms_gain;
      prod_in = cmd.mul_load ? (mul_a * mul_b) : prod_ff;

      scaled  = prod_ff[PROD_W-1:SAMPLE_W-1];
      clamped = (scaled > (PROD_W-SAMPLE_W+1)'(cfg.full_scale)) ? cfg.full_scale
                                                              : scaled[LEVEL_W-1:0];

      level_in = cmd.level_load ? clamped : level_ff;
      used_in  = cmd.level_load ? cmd.mul_peak : used_ff;

      status.block_end = (count_ff == '0) || (count_ff >= len_eff);
      status.fallback  = (clamped < cfg.low_level_threshold)
                       && (peak_ff > cfg.peak_minimum);
   end

   // result register
   always_comb begin
      out_level_in = out_level_ff;
      out_rms_in   = out_rms_ff;
      out_peak_in  = out_peak_ff;
      out_used_in  = out_used_ff;
      if (cmd.emit) begin
         out_level_in = level_ff;
         out_rms_in   = res_ff[SAMPLE_W-1:0];
         out_peak_in  = peak_ff;
         out_used_in  = used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         peak_ff  <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         peak_ff  <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      rem_ff       <= rem_in;
      work_ff      <= work_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      prod_ff      <= prod_in;
      level_ff     <= level_in;
      used_ff      <= used_in;
      out_level_ff <= out_level_in;
      out_rms_ff   <= out_rms_in;
      out_peak_ff  <= out_peak_in;
      out_used_ff  <= out_used_in;
   end

   assign level      = out_level_ff;
   assign rms_value  = out_rms_ff;
   assign peak_value = out_peak_ff;
   assign used_peak  = out_used_ff;

`ifndef SYNTHESIS
   // the mean square never exceeds a full-scale square, so the root fits
   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> res_ff <= SUM_W'(32768))
      else $error("rms out of range at result load");

   a_level_clamp: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> level_ff <= cfg.full_scale)
      else $error("level above full scale at result load");

   a_peak_tracks: assert property (@(posedge clock) disable iff (reset)
      cmd.accumulate && !cmd.emit |=> peak_ff >= $past(mag_ff))
      else $error("peak below accumulated magnitude");
`endif

endmodule

### src/rplm_ctrl.sv
module rplm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  rplm_pkg::status_type status,
   output rplm_pkg::cmd_type    cmd
);
   import rplm_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_ACC       = 11'b000_0000_0010,
      ST_LOAD      = 11'b000_0000_0100,
      ST_DIV       = 11'b000_0000_1000,
      ST_ROOT_INIT = 11'b000_0001_0000,
      ST_ROOT      = 11'b000_0010_0000,
      ST_MUL_RMS   = 11'b000_0100_0000,
      ST_CHK_RMS   = 11'b000_1000_0000,
      ST_MUL_PEAK  = 11'b001_0000_0000,
      ST_CHK_PEAK  = 11'b010_0000_0000,
      ST_DONE      = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in = status.block_end ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            cmd.div_init = 1'b1;
            iter_in  = ITER_W'(DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = ST_ROOT_INIT;
            end
         end
         ST_ROOT_INIT: begin
            cmd.root_init = 1'b1;
            iter_in  = ITER_W'(ROOT_STEPS - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = ST_MUL_RMS;
            end
         end
         ST_MUL_RMS: begin
            cmd.mul_load = 1'b1;
            state_in = ST_CHK_RMS;
         end
         ST_CHK_RMS: begin
            cmd.level_load = 1'b1;
            state_in = status.fallback ? ST_MUL_PEAK : ST_DONE;
         end
         ST_MUL_PEAK: begin
            cmd.mul_load = 1'b1;
            cmd.mul_peak = 1'b1;
            state_in = ST_CHK_PEAK;
         end
         ST_CHK_PEAK: begin
            cmd.level_load = 1'b1;
            cmd.mul_peak   = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait here while the previous result is still untaken
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded over an untaken result");

   a_block_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && status.block_end) |=> state_ff == ST_LOAD)
      else $error("closing frame did not start the divide");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");
`endif

endmodule

### src/block_rms_peak_level_meter_unit.sv
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata: sample_ch0, sample_ch1
// rsp_      out  rsp_tvalid/rsp_tready  tdata: level, rms_value, peak_value; tuser: used_peak
// csr_      in   csr_we                 csr_addr, csr_wdata
//
// a frame that does not close a block passes through transfer, then accumulate
// a closing frame then runs the 41-step restoring divider and the 21-step square
// root, a gain multiply and a level check (twice with the peak fallback), then the result load
// reset is synchronous: registers to defaults, accumulators and counter cleared
// one result register; frames keep being taken while it waits, and a block that
// closes meanwhile holds req_tready low until the result transfer
module block_rms_peak_level_meter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // sample_ch0, sample_ch1
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [47:0]                     rsp_tdata,   // level, rms_value, peak_value, zeros
   output logic [0:0]                      rsp_tuser,   // used_peak
   input  logic                            csr_we,
   input  logic [rplm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rplm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rplm_pkg::*;

   cfg_type             cfg;
   cmd_type             cmd;
   status_type          status;
   logic [LEVEL_W-1:0]  level;
   logic [SAMPLE_W-1:0] rms_value;
   logic [SAMPLE_W-1:0] peak_value;
   logic                used_peak;

   rplm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rplm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rplm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .sample_ch0 ($signed(req_tdata[15:0])),
      .sample_ch1 ($signed(req_tdata[31:16])),
      .level      (level),
      .rms_value  (rms_value),
      .peak_value (peak_value),
      .used_peak  (used_peak)
   );

   assign rsp_tdata = {4'b0000, peak_value, rms_value, level};
   assign rsp_tuser = used_peak;

endmodule

### test/tb.sv
module tb;
   import rplm_pkg::*;

   localparam int SETTLE_CYCLES = 80;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic [LEVEL_W-1:0]  level;
      logic [SAMPLE_W-1:0] rms;
      logic [SAMPLE_W-1:0] peak;
      logic                used;
   } level_report_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [47:0]           rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = CSR_NUM_CHANNELS;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // meter state as the block should hold it
   cfg_type             meter_cfg   = CFG_RESET;
   logic [SUM_W-1:0]    square_sum  = '0;
   logic [SAMPLE_W-1:0] block_peak  = '0;
   logic [COUNT_W-1:0]  frame_count = '0;

   level_report_type expected_levels[$];
   int error_count   = 0;
   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int hold_cycles   = 0;

   block_rms_peak_level_meter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned root_floor(input longint unsigned x);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x)
            r = t;
      end
      return r;
   endfunction

   function automatic logic [LEVEL_W-1:0] volts_from(input longint unsigned v,
                                                     input logic [GAIN_W-1:0] gain);
      longint unsigned p;
      p = (v * gain) >> 15;
      if (p > meter_cfg.full_scale)
         p = 64'(meter_cfg.full_scale);
      return p[LEVEL_W-1:0];
   endfunction

   task automatic meter_take_frame(input logic [SAMPLE_W-1:0] ch0, ch1);
      int                    channels;
      int                    block_len;
      logic signed [SAMPLE_W:0] mono;
      logic [SAMPLE_W:0]     mag;
      longint unsigned       frames;
      longint unsigned       rms_root;
      level_report_type      rep;
      channels = (meter_cfg.num_channels == 0) ? 1 : int'(meter_cfg.num_channels);
      if (channels > MAX_CHANNELS)
         channels = MAX_CHANNELS;
      block_len = (meter_cfg.frames_per_block == 0) ? 1 : int'(meter_cfg.frames_per_block);
      if (block_len > MAX_BLOCK_FRAMES)
         block_len = MAX_BLOCK_FRAMES;
      mono = $signed({ch0[SAMPLE_W-1], ch0});
      // average rounds toward minus infinity
      if (channels >= 2)
         mono = ($signed({ch0[SAMPLE_W-1], ch0}) + $signed({ch1[SAMPLE_W-1], ch1})) >>> 1;
      mag = mono[SAMPLE_W] ? -mono : mono;
      square_sum = square_sum + mag * mag;
      if (mag > block_peak)
         block_peak = mag[SAMPLE_W-1:0];
      frame_count = frame_count + 1'b1;
      if (frame_count != 0 && frame_count < block_len)
         return;
      frames   = (frame_count == 0) ? 64'd2048 : 64'(frame_count);
      rms_root = root_floor(square_sum / frames);
      rep.rms   = rms_root[SAMPLE_W-1:0];
      rep.peak  = block_peak;
      rep.level = volts_from(rms_root, meter_cfg.rms_gain);
      rep.used  = 1'b0;
      if (rep.level < meter_cfg.low_level_threshold && block_peak > meter_cfg.peak_minimum) begin
         rep.level = volts_from(block_peak, meter_cfg.peak_gain);
         rep.used  = 1'b1;
      end
      expected_levels.push_back(rep);
      square_sum  = '0;
      block_peak  = '0;
      frame_count = '0;
   endtask

   // entered and left at a falling edge; tvalid stays high for a following frame
   task automatic send_frame(input logic [SAMPLE_W-1:0] ch0, ch1);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ch1, ch0};
      do @(posedge clock); while (!req_tready);
      meter_take_frame(ch0, ch1);
      @(negedge clock);
   endtask

   task automatic settle_meter();
      req_tvalid <= 1'b0;
      while (expected_levels.size() != 0)
         @(negedge clock);
      // a frame that closes no block may still be in flight
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_NUM_CHANNELS:        meter_cfg.num_channels        = value[1:0];
         CSR_FRAMES_PER_BLOCK:    meter_cfg.frames_per_block    = value[COUNT_W-1:0];
         CSR_RMS_GAIN:            meter_cfg.rms_gain            = value[GAIN_W-1:0];
         CSR_PEAK_GAIN:           meter_cfg.peak_gain           = value[GAIN_W-1:0];
         CSR_FULL_SCALE:          meter_cfg.full_scale          = value[LEVEL_W-1:0];
         CSR_LOW_LEVEL_THRESHOLD: meter_cfg.low_level_threshold = value[LEVEL_W-1:0];
         CSR_PEAK_MINIMUM:        meter_cfg.peak_minimum        = value[SAMPLE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 7))
         0: s = 16'h8000;
         1: s = 16'h7fff;
         2, 3: begin
            s = 16'($urandom_range(0, 700));
            if ($urandom_range(0, 1))
               s = -s;
         end
         default: s = 16'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_setting(input int width);
      logic [CSR_DATA_W-1:0] all_ones;
      all_ones = 16'((32'd1 << width) - 1);
      case ($urandom_range(0, 4))
         0: return '0;
         1: return all_ones;
         2: return 16'($urandom_range(0, 64));
         default: return 16'($urandom) & all_ones;
      endcase
   endfunction

   task automatic test_reset_config();
      repeat (256) send_frame(pick_sample(), pick_sample());
   endtask

   task automatic test_mono_extremes();
      settle_meter();
      set_register(CSR_FRAMES_PER_BLOCK, 1);
      send_frame(16'h0000, 16'h1234);
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h8000, 16'h7fff);
      send_frame(16'hffff, 16'h0000);
      send_frame(16'h0001, 16'hffff);
      send_frame(16'd329, 16'h8000);
   endtask

   task automatic test_stereo_mix();
      settle_meter();
      set_register(CSR_NUM_CHANNELS, 2);
      send_frame(16'h7fff, 16'h7fff);
      send_frame(16'h8000, 16'h8000);
      send_frame(16'h8000, 16'h7fff);
      send_frame(16'hffff, 16'h0000);
      send_frame(16'h0001, 16'h0000);
      // channel counts out of range clamp to the nearest legal one
      settle_meter();
      set_register(CSR_NUM_CHANNELS, 3);
      send_frame(16'hfffd, 16'h0000);
      settle_meter();
      set_register(CSR_NUM_CHANNELS, 0);
      send_frame(16'd5, 16'h8000);
   endtask

   task automatic test_peak_fallback();
      settle_meter();
      set_register(CSR_NUM_CHANNELS, 1);
      set_register(CSR_RMS_GAIN, 0);
      send_frame(16'd328, 16'h0000);
      send_frame(16'd329, 16'h0000);
      settle_meter();
      set_register(CSR_PEAK_GAIN, 16'hffff);
      set_register(CSR_FULL_SCALE, 16'h0fff);
      send_frame(16'h8000, 16'h0000);
      settle_meter();
      set_register(CSR_PEAK_MINIMUM, 16'hffff);
      send_frame(16'h8000, 16'h0000);
      settle_meter();
      set_register(CSR_LOW_LEVEL_THRESHOLD, 0);
      set_register(CSR_PEAK_MINIMUM, 328);
      send_frame(16'h7fff, 16'h0000);
   endtask

   task automatic test_block_length_edges();
      settle_meter();
      set_register(CSR_RMS_GAIN, 12800);
      set_register(CSR_PEAK_GAIN, 2560);
      set_register(CSR_FULL_SCALE, 2560);
      set_register(CSR_LOW_LEVEL_THRESHOLD, 26);
      set_register(CSR_FRAMES_PER_BLOCK, 0);
      send_frame(16'h4000, 16'h0000);
      settle_meter();
      set_register(CSR_FRAMES_PER_BLOCK, 4);
      repeat (3) send_frame(pick_sample(), pick_sample());
      // shorter length mid-block closes it on the next frame
      settle_meter();
      set_register(CSR_FRAMES_PER_BLOCK, 2);
      send_frame(pick_sample(), pick_sample());
   endtask

   task automatic test_random_blocks(input int frame_budget);
      int sent;
      int block_len;
      int pick;
      sent = 0;
      while (sent < frame_budget) begin
         settle_meter();
         if ($urandom_range(0, 1))
            set_register(CSR_NUM_CHANNELS, 16'($urandom_range(0, 3)));
         if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               set_register(CSR_FRAMES_PER_BLOCK, 0);
            else if (pick < 14)
               set_register(CSR_FRAMES_PER_BLOCK, 16'($urandom_range(1, 4)));
            else if (pick < 19)
               set_register(CSR_FRAMES_PER_BLOCK, 16'($urandom_range(5, 16)));
            else
               set_register(CSR_FRAMES_PER_BLOCK, 16'($urandom_range(17, 64)));
         end
         if ($urandom_range(0, 1)) set_register(CSR_RMS_GAIN, pick_setting(GAIN_W));
         if ($urandom_range(0, 1)) set_register(CSR_PEAK_GAIN, pick_setting(GAIN_W));
         if ($urandom_range(0, 1)) set_register(CSR_FULL_SCALE, pick_setting(LEVEL_W));
         if ($urandom_range(0, 1))
            set_register(CSR_LOW_LEVEL_THRESHOLD, pick_setting(LEVEL_W));
         if ($urandom_range(0, 1)) set_register(CSR_PEAK_MINIMUM, pick_setting(SAMPLE_W));
         block_len = (meter_cfg.frames_per_block == 0) ? 1 : int'(meter_cfg.frames_per_block);
         if (block_len > MAX_BLOCK_FRAMES)
            block_len = MAX_BLOCK_FRAMES;
         repeat ($urandom_range(1, 5) * block_len) begin
            send_frame(pick_sample(), pick_sample());
            sent++;
         end
         // sometimes add frames that may leave a block half done across the next register change
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, block_len)) begin
               send_frame(pick_sample(), pick_sample());
               sent++;
            end
         end
      end
   endtask

   task automatic test_result_backpressure();
      settle_meter();
      set_register(CSR_FRAMES_PER_BLOCK, 2);
      hold_cycles = 400;
      repeat (40) send_frame(pick_sample(), pick_sample());
   endtask

   task automatic test_longest_block();
      settle_meter();
      // flush any partial block first
      set_register(CSR_FRAMES_PER_BLOCK, 1);
      send_frame(pick_sample(), pick_sample());
      settle_meter();
      set_register(CSR_NUM_CHANNELS, 2);
      set_register(CSR_RMS_GAIN, 12800);
      set_register(CSR_FRAMES_PER_BLOCK, 16'h07ff);
      repeat (MAX_BLOCK_FRAMES / 2) send_frame(16'h8000, 16'h8000);
      repeat (MAX_BLOCK_FRAMES / 2) send_frame(pick_sample(), pick_sample());
   endtask

   // result side: long hold-off on request, otherwise random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   always @(posedge clock) begin
      level_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_levels.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected level transfer: level %0d rms %0d peak %0d used %0d",
                        rsp_tdata[11:0], rsp_tdata[27:12], rsp_tdata[43:28], rsp_tuser[0]);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_tdata[11:0] !== want.level || rsp_tdata[27:12] !== want.rms ||
                rsp_tdata[43:28] !== want.peak || rsp_tuser[0] !== want.used) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("level mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                           want.level, want.rms, want.peak, want.used, rsp_tdata[11:0],
                           rsp_tdata[27:12], rsp_tdata[43:28], rsp_tuser[0]);
            end
         end
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 38;
      take_idle_pct = 74;
      test_reset_config();
      test_mono_extremes();
      test_stereo_mix();
      test_peak_fallback();
      test_block_length_edges();
      test_random_blocks(130);
      send_idle_pct = 74;
      take_idle_pct = 38;
      test_random_blocks(130);
      send_idle_pct = 0;
      take_idle_pct = 0;
      test_result_backpressure();
      test_random_blocks(130);
      test_longest_block();
      settle_meter();
      if (error_count == 0 && expected_levels.size() == 0)
         $display("block_rms_peak_level_meter_unit: match");
      else
         $display("block_rms_peak_level_meter_unit: mismatch");
      $finish;
   end

   initial begin
      #(12 * 1000000);
      $display("block_rms_peak_level_meter_unit: mismatch");
      $finish;
   end

endmodule
